// ===== sv/bbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_pkg
// Shared widths, codes and controller/datapath handshake types for the
// bitmap block pool allocator.
// ----------------------------------------------------------------------------
package bbpa_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W       = 2;
  localparam int OFFSET_W   = 20;
  localparam int ELEM_W     = 16;
  localparam int BCOUNT_W   = 9;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 8;
  localparam int COUNT_W    = 9;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (STATUS_W + INDEX_W + OFFSET_W + COUNT_W + 2);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OFF  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT   = 1'd1;

  typedef struct packed {
    logic                load;
    logic                rd_hint;
    logic                rd_scan;
    logic                rd_idx;
    logic                div_step;
    logic                alloc_hint;
    logic                alloc_scan;
    logic                free_commit;
    logic                drop_hint;
    logic                clear_all;
    logic                mul;
    logic                finish;
    logic [STATUS_W-1:0] fin_status;
    logic                fin_idx;
    logic                fin_off;
  } bbpa_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            hint_ok;
    logic            scan_hit;
    logic            scan_last;
    logic            div_done;
    logic            div_bad;
    logic            bit_used;
    logic            out_free;
  } bbpa_sts_t;

endpackage

// ===== sv/bbpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bbpa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_datapath
// Configuration registers, used-bit map (byte rows in RAM with per-row valid
// bits), row scan encoder, restoring divider, offset multiplier and the
// result register.
// ----------------------------------------------------------------------------
module bbpa_datapath import bbpa_pkg::*; #(
  parameter int MAX_BLOCKS  = 256,
  parameter int OFFSET_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  input  bbpa_cmd_t             cmd_i,
  output bbpa_sts_t             sts_o
);

  localparam int ROWS   = MAX_BLOCKS / 8;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int D_W    = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
  localparam int DC_W   = $clog2(D_W + 1);
  localparam int CMP_A  = (D_W > CNT_W) ? D_W : CNT_W;
  localparam int CMP_W  = (CMP_A > BCOUNT_W) ? CMP_A : BCOUNT_W;
  localparam int MUL_W  = IDX_W + ELEM_W;

  // Configuration.
  logic [ELEM_W-1:0]   eb_q;
  logic [BCOUNT_W-1:0] bc_q;

  // Allocation state.
  logic [ROWS-1:0]     row_vld_q;
  logic [CNT_W-1:0]    total_q;
  logic [IDX_W-1:0]    hint_q;
  logic                hint_vld_q;

  // Per-item working registers.
  logic [OP_W-1:0]     op_q;
  logic [ROW_W-1:0]    scan_ctr_q;
  logic [ROW_W-1:0]    rd_addr_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    idx_q;
  logic [MUL_W-1:0]    prod_q;
  logic [ELEM_W:0]     rem_q;
  logic [D_W-1:0]      quot_q;
  logic [DC_W-1:0]     div_cnt_q;
  logic                out_vld_q;
  logic [OUT_DATA_W-1:0] out_q;

  // RAM port.
  logic                ram_re;
  logic [ROW_W-1:0]    ram_raddr;
  logic [7:0]          ram_rdata;
  logic                ram_we;
  logic [7:0]          ram_wdata;

  logic [CMP_W-1:0]    cap;
  logic [7:0]          rd_row;
  logic [7:0]          free_bits;
  logic [2:0]          enc;
  logic                scan_hit;
  logic [2:0]          bsel;
  logic [7:0]          bmask;
  logic [ELEM_W:0]     rem_sh;
  logic                rem_ge;
  logic [OFFSET_W-1:0] granted;
  logic [MUL_W+OFFSET_W-1:0] prod_ext;

  // Block counts above the map size act as the map size.
  assign cap = (CMP_W'(bc_q) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : CMP_W'(bc_q);

  // Rows never written since reset or the last clear read as all free.
  assign rd_row = rd_vld_q ? ram_rdata : 8'd0;

  always_comb begin
    logic [CMP_W-1:0] pos;
    pos = '0;
    for (int b = 0; b < 8; b++) begin
      pos          = (CMP_W'(rd_addr_q) << 3) | CMP_W'(b);
      free_bits[b] = !rd_row[b] && (pos < cap);
    end
  end

  always_comb begin
    scan_hit = 1'b0;
    enc      = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (free_bits[b]) begin
        scan_hit = 1'b1;
        enc      = 3'(b);
      end
    end
  end

  always_comb begin
    ram_re    = cmd_i.rd_hint | cmd_i.rd_scan | cmd_i.rd_idx;
    ram_raddr = scan_ctr_q;
    if (cmd_i.rd_hint) begin
      ram_raddr = ROW_W'(hint_q >> 3);
    end else if (cmd_i.rd_idx) begin
      ram_raddr = ROW_W'(quot_q >> 3);
    end
  end

  always_comb begin
    bsel = idx_q[2:0];
    if (cmd_i.alloc_hint) begin
      bsel = hint_q[2:0];
    end else if (cmd_i.alloc_scan) begin
      bsel = enc;
    end
  end

  assign bmask     = 8'd1 << bsel;
  assign ram_we    = cmd_i.alloc_hint | cmd_i.alloc_scan | cmd_i.free_commit;
  assign ram_wdata = cmd_i.free_commit ? (rd_row & ~bmask) : (rd_row | bmask);

  bbpa_ram #(
    .WIDTH (8),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rd_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One restoring division step per cycle.
  assign rem_sh = {rem_q[ELEM_W-1:0], quot_q[D_W-1]};
  assign rem_ge = rem_sh >= {1'b0, eb_q};

  assign prod_ext = {{OFFSET_W{1'b0}}, prod_q};
  assign granted  = OFFSET_W'(prod_ext[D_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eb_q       <= ELEM_W'(1);
      bc_q       <= '0;
      row_vld_q  <= '0;
      total_q    <= '0;
      hint_q     <= '0;
      hint_vld_q <= 1'b0;
      scan_ctr_q <= '0;
      div_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ELEMENT_BYTES: eb_q <= cfg_wdata_i;
          REG_BLOCK_COUNT:   bc_q <= cfg_wdata_i[BCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        scan_ctr_q <= '0;
        div_cnt_q  <= '0;
      end
      if (cmd_i.rd_scan) begin
        scan_ctr_q <= scan_ctr_q + ROW_W'(1);
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DC_W'(1);
      end
      if (ram_we) begin
        row_vld_q[rd_addr_q] <= 1'b1;
      end
      if (cmd_i.drop_hint) begin
        hint_vld_q <= 1'b0;
      end
      if (cmd_i.alloc_hint || cmd_i.alloc_scan) begin
        total_q <= total_q + CNT_W'(1);
      end
      if (cmd_i.free_commit) begin
        if (total_q != '0) begin
          total_q <= total_q - CNT_W'(1);
        end
        hint_q     <= idx_q;
        hint_vld_q <= 1'b1;
      end
      if (cmd_i.clear_all) begin
        row_vld_q <= '0;
        total_q   <= '0;
      end
      if (cmd_i.finish) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= s_tdata_i[1:0];
      quot_q <= s_tdata_i[2 +: D_W];
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? (rem_sh - {1'b0, eb_q}) : rem_sh;
      quot_q <= {quot_q[D_W-2:0], rem_ge};
    end
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
      rd_vld_q  <= row_vld_q[ram_raddr];
    end
    if (cmd_i.rd_idx) begin
      idx_q <= IDX_W'(quot_q);
    end
    if (cmd_i.alloc_hint) begin
      idx_q <= hint_q;
    end
    if (cmd_i.alloc_scan) begin
      idx_q <= IDX_W'({rd_addr_q, enc});
    end
    if (cmd_i.mul) begin
      prod_q <= MUL_W'(idx_q) * MUL_W'(eb_q);
    end
    if (cmd_i.finish) begin
      out_q <= {{OUT_PAD_W{1'b0}},
                (total_q == '0),
                (CMP_W'(total_q) >= cap),
                COUNT_W'(total_q),
                (cmd_i.fin_off ? granted : OFFSET_W'(0)),
                (cmd_i.fin_idx ? INDEX_W'(idx_q) : INDEX_W'(0)),
                cmd_i.fin_status};
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_q;

  always_comb begin
    sts_o.op        = op_q;
    sts_o.full      = CMP_W'(total_q) >= cap;
    sts_o.hint_ok   = hint_vld_q && (CMP_W'(hint_q) < cap) && !rd_row[hint_q[2:0]];
    sts_o.scan_hit  = scan_hit;
    sts_o.scan_last = rd_addr_q == ROW_W'((cap - CMP_W'(1)) >> 3);
    sts_o.div_done  = div_cnt_q == DC_W'(D_W);
    sts_o.div_bad   = (eb_q == '0) || (rem_q != '0) || (CMP_W'(quot_q) >= cap);
    sts_o.bit_used  = rd_row[idx_q[2:0]];
    sts_o.out_free  = !out_vld_q || m_tready_i;
  end

endmodule

// ===== sv/bbpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbpa_ctrl
// Operation sequencer: decodes each item and steps the datapath through
// hint check, bitmap scan, division and result hand-off.
// ----------------------------------------------------------------------------
module bbpa_ctrl import bbpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  bbpa_sts_t sts_i,
  output bbpa_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_HINT   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_FREE   = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  logic [3:0]          state_q, state_d;
  logic [STATUS_W-1:0] code_q, code_d;
  logic                use_idx_q, use_idx_d;
  logic                use_off_q, use_off_d;

  assign s_tready_o = state_q == S_IDLE;

  always_comb begin
    state_d   = state_q;
    code_d    = code_q;
    use_idx_d = use_idx_q;
    use_off_d = use_off_q;
    cmd_o     = '0;
    cmd_o.fin_status = code_q;
    cmd_o.fin_idx    = use_idx_q;
    cmd_o.fin_off    = use_off_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          code_d     = ST_OK;
          use_idx_d  = 1'b0;
          use_off_d  = 1'b0;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_ALLOC: begin
            if (sts_i.full) begin
              code_d  = ST_FULL;
              state_d = S_DONE;
            end else begin
              cmd_o.rd_hint = 1'b1;
              state_d       = S_HINT;
            end
          end
          OP_FREE: state_d = S_DIV;
          OP_CLEAR: begin
            cmd_o.clear_all = 1'b1;
            state_d         = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_HINT: begin
        // Any allocation that gets this far consumes the hint.
        cmd_o.drop_hint = 1'b1;
        if (sts_i.hint_ok) begin
          cmd_o.alloc_hint = 1'b1;
          state_d          = S_MUL;
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          cmd_o.alloc_scan = 1'b1;
          state_d          = S_MUL;
        end else if (sts_i.scan_last) begin
          code_d  = ST_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_scan = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        use_idx_d = 1'b1;
        use_off_d = 1'b1;
        state_d   = S_DONE;
      end
      S_DIV: begin
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (sts_i.div_bad) begin
          code_d  = ST_BAD_OFF;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d      = S_FREE;
        end
      end
      S_FREE: begin
        use_idx_d = 1'b1;
        if (sts_i.bit_used) begin
          cmd_o.free_commit = 1'b1;
        end else begin
          code_d = ST_NOT_USED;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      code_q    <= ST_OK;
      use_idx_q <= 1'b0;
      use_off_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      code_q    <= code_d;
      use_idx_q <= use_idx_d;
      use_off_q <= use_off_d;
    end
  end

endmodule

// ===== sv/bitmap_block_pool_allocator_core.sv =====
`timescale 1ns / 1ps
// Paths from accept to result: clear, no-op and allocate on a full count go from decode to the result;
// allocate tries the hint first, then falls back to a scan of the byte rows of the map in order
// (one RAM row read per cycle, at most MAX_BLOCKS/8 rows), and multiplies the index into an offset;
// free divides the offset in a bit-serial divider over min(OFFSET_BITS,20) quotient bits.
// One item is in work at a time; the next item is taken once the result register is loaded.
// Reset empties the map at once through per-row valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// bitmap_block_pool_allocator_core
// Fixed-size block pool allocator with one used bit per block.
// ----------------------------------------------------------------------------
module bitmap_block_pool_allocator_core import bbpa_pkg::*; #(
  parameter int MAX_BLOCKS  = 256,
  parameter int OFFSET_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // op [1:0], block_offset [21:2], zero [23:22]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status [1:0], block_index [9:2], granted_offset [29:10], used_count [38:30],
  // pool_full [39], pool_empty [40], zero [47:41]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  bbpa_cmd_t cmd;
  bbpa_sts_t sts;

  bbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbpa_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap block pool allocator. A directed run
// covers the corner cases and is followed by random phases under several pool
// geometries and idle patterns. A tracking model of the used map predicts
// every reply, and the bench compares each reply field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import bbpa_pkg::*;

  localparam int POOL_SLOTS  = 256;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 168;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
    logic                full;
    logic                empty;
  } reply_t;

  class pool_tracker;
    bit                  taken[POOL_SLOTS];
    int                  in_use;
    logic [INDEX_W-1:0]  hint_idx;
    bit                  hint_ok;
    int                  elem_size;
    int                  blk_count;
    reply_t              pending_replies[$];
    int                  errors;
    int                  checked;
    int                  by_status[4];

    function new();
      in_use    = 0;
      hint_idx  = '0;
      hint_ok   = 0;
      elem_size = 1;
      blk_count = 0;
      errors    = 0;
      checked   = 0;
      foreach (taken[i]) taken[i] = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int value);
      if (idx == REG_ELEMENT_BYTES) elem_size = value & 'hFFFF;
      else if (idx == REG_BLOCK_COUNT) blk_count = value & 'h1FF;
    endfunction

    function int usable();
      return (blk_count > POOL_SLOTS) ? POOL_SLOTS : blk_count;
    endfunction

    function logic [OFFSET_W-1:0] offset_of(int idx);
      longint prod;
      prod = longint'(idx) * longint'(elem_size);
      return prod[OFFSET_W-1:0];
    endfunction

    // Prefers a block that is really in use, so that most frees succeed.
    function int pick_taken();
      int cap;
      int start;
      cap = usable();
      if (cap == 0) return $urandom_range(7);
      start = $urandom_range(cap - 1);
      for (int i = 0; i < cap; i++) begin
        if (taken[(start + i) % cap]) return (start + i) % cap;
      end
      return start;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [OFFSET_W-1:0] off);
      reply_t r;
      int     cap;
      int     idx;
      bit     found;
      cap      = usable();
      r.status = ST_OK;
      r.index  = '0;
      r.offset = '0;
      case (op)
        OP_ALLOC: begin
          if (in_use >= cap) begin
            r.status = ST_FULL;
          end else begin
            found = 0;
            idx   = 0;
            if (hint_ok && hint_idx < cap && !taken[hint_idx]) begin
              idx   = hint_idx;
              found = 1;
            end
            hint_ok = 0;
            for (int i = 0; i < cap && !found; i++) begin
              if (!taken[i]) begin
                idx   = i;
                found = 1;
              end
            end
            if (!found) begin
              r.status = ST_FULL;
            end else begin
              taken[idx] = 1;
              in_use++;
              r.index  = idx[INDEX_W-1:0];
              r.offset = offset_of(idx);
            end
          end
        end
        OP_FREE: begin
          if (elem_size == 0 || (int'(off) % elem_size) != 0) begin
            r.status = ST_BAD_OFF;
          end else begin
            idx = int'(off) / elem_size;
            if (idx >= cap) begin
              r.status = ST_BAD_OFF;
            end else if (!taken[idx]) begin
              r.status = ST_NOT_USED;
              r.index  = idx[INDEX_W-1:0];
            end else begin
              taken[idx] = 0;
              if (in_use > 0) in_use--;
              hint_idx = idx[INDEX_W-1:0];
              hint_ok  = 1;
              r.index  = idx[INDEX_W-1:0];
            end
          end
        end
        OP_CLEAR: begin
          foreach (taken[i]) taken[i] = 0;
          in_use = 0;
        end
        default: ;
      endcase
      r.count = in_use[COUNT_W-1:0];
      r.full  = (in_use >= cap);
      r.empty = (in_use == 0);
      pending_replies.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] d);
      reply_t r;
      if (pending_replies.size() == 0) begin
        $error("reply 0x%0h arrived with no request outstanding", d);
        errors++;
        return;
      end
      r = pending_replies.pop_front();
      checked++;
      by_status[r.status]++;
      compare_field("status",         int'(r.status), int'(d[1:0]));
      compare_field("block_index",    int'(r.index),  int'(d[9:2]));
      compare_field("granted_offset", int'(r.offset), int'(d[29:10]));
      compare_field("used_count",     int'(r.count),  int'(d[38:30]));
      compare_field("pool_full",      int'(r.full),   int'(d[39]));
      compare_field("pool_empty",     int'(r.empty),  int'(d[40]));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // op [1:0], block_offset [21:2], zero [23:22]
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // status [1:0], block_index [9:2], granted_offset [29:10], used_count [38:30],
  // pool_full [39], pool_empty [40], zero [47:41]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  pool_tracker tracker = new();
  int          cycles = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  bitmap_block_pool_allocator_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d replies outstanding.",
               cycles, tracker.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Requests are predicted at the edge that accepts them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_request(s_axis_tdata[1:0], s_axis_tdata[21:2]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_reply(m_axis_tdata);
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // All driving tasks start and end at a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [OFFSET_W-1:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(IN_DATA_W - OP_W - OFFSET_W){1'b0}}, off, op};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic wait_replies();
    s_axis_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  // Lets the allocator go fully idle before the pool geometry changes.
  task automatic settle_and_config(input int elem, input int count);
    wait_replies();
    repeat (40) @(negedge clk_i);
    write_reg(REG_ELEMENT_BYTES, elem);
    write_reg(REG_BLOCK_COUNT, count);
  endtask

  task automatic run_directed();
    // Empty pool geometry straight out of reset.
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, '0);
    send_item(OP_NOP, 20'hFFFFF);
    settle_and_config(16, 8);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 20'd16);
    send_item(OP_FREE, 20'd16);
    send_item(OP_FREE, 20'd17);
    send_item(OP_FREE, 20'd128);
    send_item(OP_FREE, 20'hFFFFF);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 20'd0);
    send_item(OP_FREE, 20'd32);
    // Shrinking the pool leaves the hint out of range.
    settle_and_config(16, 2);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    // Block 1 is still marked used but sits beyond the shrunk pool.
    settle_and_config(16, 1);
    send_item(OP_FREE, 20'd16);
    send_item(OP_CLEAR, '0);
    settle_and_config(0, 256);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 20'd0);
    send_item(OP_ALLOC, '0);
    settle_and_config(65535, 256);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 20'd65535);
    send_item(OP_FREE, 20'hFFFFF);
    send_item(OP_CLEAR, '0);
  endtask

  task automatic run_random(input int count, input int alloc_pct);
    int              pick;
    logic [OP_W-1:0] op;
    logic [OFFSET_W-1:0] off;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) == 0) wait_replies();
      pick = $urandom_range(99);
      off  = OFFSET_W'($urandom);
      if (pick < alloc_pct) begin
        op = OP_ALLOC;
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          op  = OP_FREE;
          off = tracker.offset_of(tracker.pick_taken());
        end else if (pick < 80) begin
          op = OP_FREE;
        end else if (pick < 88) begin
          op  = OP_FREE;
          off = tracker.offset_of(tracker.pick_taken()) + 20'd1;
        end else if (pick < 95) begin
          op = OP_CLEAR;
        end else begin
          op = OP_NOP;
        end
      end
      send_item(op, off);
    end
  endtask

  initial begin
    int elems[8];
    int counts[8];
    int allocs[8];
    elems  = '{1, 65535, 12, 4096, 0, 3, 1, 7};
    counts = '{8, 256, 13, 256, 5, 1, 0, 40};
    allocs = '{50, 85, 55, 75, 50, 50, 60, 60};
    elems[6]  = $urandom_range(65535, 1);
    counts[6] = $urandom_range(256);
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    for (int p = 0; p < 8; p++) begin
      settle_and_config(elems[p], counts[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      run_random(PHASE_ITEMS, allocs[p]);
    end

    wait_replies();
    repeat (60) @(negedge clk_i);
    $display("Sent %0d items over 8 pool geometries; %0d replies checked.",
             items_sent, tracker.checked);
    $display("Replies seen: %0d ok, %0d full, %0d bad offset, %0d block not in use.",
             tracker.by_status[ST_OK], tracker.by_status[ST_FULL],
             tracker.by_status[ST_BAD_OFF], tracker.by_status[ST_NOT_USED]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bbpa_pkg.sv
sv/bbpa_ram.sv
sv/bbpa_datapath.sv
sv/bbpa_ctrl.sv
sv/bitmap_block_pool_allocator_core.sv
tb/tb_top.sv
